// ----- src/afct_pkg.sv -----
// Shared types and constants for the box versus clip-volume corner test.
`default_nettype none
package afct_pkg;

  localparam int NUM_PAIRS   = 8;
  localparam int NUM_ENTRIES = 2 * NUM_PAIRS;
  localparam int NUM_ROWS    = 4;
  localparam int NUM_TERMS   = 6;
  localparam int NUM_XY      = 4;
  localparam int NUM_ZW      = 2;
  localparam int NUM_CORNERS = 8;
  localparam int W_ROW       = 3;
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;
  localparam int W_SHIFT     = 16;

  typedef logic        [DATA_W-1:0] pair_t;
  typedef logic signed [31:0]       coord_t;
  typedef logic signed [63:0]       prod_t;
  typedef logic signed [64:0]       part_t;
  typedef logic signed [65:0]       clip_t;
  typedef logic signed [66:0]       margin_t;

  // Identity matrix after reset.
  localparam pair_t PAIR_RESET [NUM_PAIRS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

endpackage
`default_nettype wire

// ----- src/aabb_frustum_corner_test_top.sv -----
// Top level: matrix registers, APB port and the four-stage culling pipeline.
`default_nettype none
// Tests one axis-aligned box per transaction against the clip volume of the
// programmed 4x4 column-major Q16.16 matrix: the box is visible when any of
// its eight corners satisfies -w <= x, y, z <= w, all math exact. One box is
// accepted every cycle while the output is not stalled, passing through the
// multiply, partial sum, corner sum and compare/output registers. All stages
// move on one shared enable, so a stalled output holds the whole pipe without
// loss. The matrix is written as eight 64-bit entry pairs at byte address 8*k
// and must only be changed while no box is in flight; it resets to the identity.
module aabb_frustum_corner_test_top (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  afct_pkg::coord_t               in_box_max_x,
  input  afct_pkg::coord_t               in_box_min_x,
  input  afct_pkg::coord_t               in_box_max_y,
  input  afct_pkg::coord_t               in_box_min_y,
  input  afct_pkg::coord_t               in_box_max_z,
  input  afct_pkg::coord_t               in_box_min_z,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           out_visible,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [afct_pkg::ADDR_W-1:0]    paddr,
  input  wire  [afct_pkg::DATA_W-1:0]    pwdata,
  output logic [afct_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  afct_pkg::pair_t  mat_pair_r [afct_pkg::NUM_PAIRS];
  afct_pkg::coord_t mat [afct_pkg::NUM_ENTRIES];
  logic [2:0]       reg_idx;
  logic             adv;
  logic             mul_vld;
  logic             sum_vld;
  afct_pkg::prod_t  prod [afct_pkg::NUM_ROWS][afct_pkg::NUM_TERMS];
  afct_pkg::clip_t  clip [afct_pkg::NUM_ROWS][afct_pkg::NUM_CORNERS];

  assign reg_idx = paddr[afct_pkg::ADDR_W-1:3];
  assign pready  = 1'b1;
  assign prdata  = mat_pair_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_pair_r <= afct_pkg::PAIR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      mat_pair_r[reg_idx] <= pwdata;
    end
  end

  // even entry in the low word, odd entry in the high word
  always_comb begin
    for (int i = 0; i < afct_pkg::NUM_ENTRIES; i++) begin
      mat[i] = mat_pair_r[i >> 1][32 * (i & 1) +: 32];
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  afct_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .vld       (in_valid),
    .mat       (mat),
    .box_max_x (in_box_max_x),
    .box_min_x (in_box_min_x),
    .box_max_y (in_box_max_y),
    .box_min_y (in_box_min_y),
    .box_max_z (in_box_max_z),
    .box_min_z (in_box_min_z),
    .vld_r     (mul_vld),
    .prod_r    (prod)
  );

  afct_sum u_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld    (mul_vld),
    .mat    (mat),
    .prod   (prod),
    .vld_r  (sum_vld),
    .clip_r (clip)
  );

  afct_cmp u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .vld       (sum_vld),
    .clip      (clip),
    .vld_r     (out_valid),
    .visible_r (out_visible)
  );

endmodule
`default_nettype wire

// ----- src/afct_mul.sv -----
// Stage 1: the 24 matrix entry by box coordinate products.
`default_nettype none
module afct_mul (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  wire                   vld,
  input  afct_pkg::coord_t      mat [afct_pkg::NUM_ENTRIES],
  input  afct_pkg::coord_t      box_max_x,
  input  afct_pkg::coord_t      box_min_x,
  input  afct_pkg::coord_t      box_max_y,
  input  afct_pkg::coord_t      box_min_y,
  input  afct_pkg::coord_t      box_max_z,
  input  afct_pkg::coord_t      box_min_z,
  output logic                  vld_r,
  output afct_pkg::prod_t       prod_r [afct_pkg::NUM_ROWS][afct_pkg::NUM_TERMS]
);

  afct_pkg::coord_t coord [afct_pkg::NUM_TERMS];
  afct_pkg::prod_t  prod_nxt [afct_pkg::NUM_ROWS][afct_pkg::NUM_TERMS];

  // term t: axis t/2 (x, y, z), max when t is even
  assign coord[0] = box_max_x;
  assign coord[1] = box_min_x;
  assign coord[2] = box_max_y;
  assign coord[3] = box_min_y;
  assign coord[4] = box_max_z;
  assign coord[5] = box_min_z;

  always_comb begin
    for (int r = 0; r < afct_pkg::NUM_ROWS; r++) begin
      for (int t = 0; t < afct_pkg::NUM_TERMS; t++) begin
        prod_nxt[r][t] = afct_pkg::prod_t'(mat[r + afct_pkg::NUM_ROWS * (t >> 1)])
                       * afct_pkg::prod_t'(coord[t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/afct_sum.sv -----
// Stages 2 and 3: partial sums, then the clip coordinate of every row at every corner.
`default_nettype none
module afct_sum (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  wire                   vld,
  input  afct_pkg::coord_t      mat [afct_pkg::NUM_ENTRIES],
  input  afct_pkg::prod_t       prod [afct_pkg::NUM_ROWS][afct_pkg::NUM_TERMS],
  output logic                  vld_r,
  output afct_pkg::clip_t       clip_r [afct_pkg::NUM_ROWS][afct_pkg::NUM_CORNERS]
);

  logic            vld_a_r;
  afct_pkg::part_t xy_r  [afct_pkg::NUM_ROWS][afct_pkg::NUM_XY];
  afct_pkg::part_t xy_nxt [afct_pkg::NUM_ROWS][afct_pkg::NUM_XY];
  afct_pkg::part_t zw_r  [afct_pkg::NUM_ROWS][afct_pkg::NUM_ZW];
  afct_pkg::part_t zw_nxt [afct_pkg::NUM_ROWS][afct_pkg::NUM_ZW];
  afct_pkg::clip_t clip_nxt [afct_pkg::NUM_ROWS][afct_pkg::NUM_CORNERS];

  always_comb begin
    for (int r = 0; r < afct_pkg::NUM_ROWS; r++) begin
      for (int j = 0; j < afct_pkg::NUM_XY; j++) begin
        xy_nxt[r][j] = afct_pkg::part_t'(prod[r][j & 1])
                     + afct_pkg::part_t'(prod[r][2 + (j >> 1)]);
      end
      // translation column times w = 1.0
      for (int k = 0; k < afct_pkg::NUM_ZW; k++) begin
        zw_nxt[r][k] = afct_pkg::part_t'(prod[r][4 + k])
                     + (afct_pkg::part_t'(mat[r + 3 * afct_pkg::NUM_ROWS])
                        <<< afct_pkg::W_SHIFT);
      end
    end
  end

  // corner c: x from bit 0, y from bit 1, z from bit 2 (0 = max)
  always_comb begin
    for (int r = 0; r < afct_pkg::NUM_ROWS; r++) begin
      for (int c = 0; c < afct_pkg::NUM_CORNERS; c++) begin
        clip_nxt[r][c] = afct_pkg::clip_t'(xy_r[r][c & 3])
                       + afct_pkg::clip_t'(zw_r[r][c >> 2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld;
      vld_r   <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xy_r   <= xy_nxt;
      zw_r   <= zw_nxt;
      clip_r <= clip_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/afct_cmp.sv -----
// Stage 4: per-corner range check against w and the output register.
`default_nettype none
module afct_cmp (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  wire                   vld,
  input  afct_pkg::clip_t       clip [afct_pkg::NUM_ROWS][afct_pkg::NUM_CORNERS],
  output logic                  vld_r,
  output logic                  visible_r
);

  logic [afct_pkg::NUM_CORNERS-1:0] in_vol;
  afct_pkg::margin_t                lo_m;
  afct_pkg::margin_t                hi_m;

  // -w <= c <= w  <=>  c + w >= 0 and w - c >= 0
  always_comb begin
    in_vol = '1;
    lo_m   = '0;
    hi_m   = '0;
    for (int c = 0; c < afct_pkg::NUM_CORNERS; c++) begin
      for (int r = 0; r < afct_pkg::W_ROW; r++) begin
        lo_m = afct_pkg::margin_t'(clip[r][c])
             + afct_pkg::margin_t'(clip[afct_pkg::W_ROW][c]);
        hi_m = afct_pkg::margin_t'(clip[afct_pkg::W_ROW][c])
             - afct_pkg::margin_t'(clip[r][c]);
        if (lo_m[$bits(afct_pkg::margin_t)-1] || hi_m[$bits(afct_pkg::margin_t)-1]) begin
          in_vol[c] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visible_r <= |in_vol;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_aabb_frustum_corner_test_top.sv -----
// Self-checking testbench for the box versus clip-volume corner test.
`timescale 1ns / 100ps
module tb_aabb_frustum_corner_test_top;
  import afct_pkg::*;

  localparam int          PAIR_STRIDE = 8;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          SETTLE_CYC  = 6;
  localparam int          RAND_BOXES  = 180;
  localparam coord_t      ONE         = 32'sh0001_0000;
  localparam coord_t      CMAX        = 32'sh7FFF_FFFF;
  localparam coord_t      CMIN        = 32'sh8000_0000;

  typedef logic signed [67:0] clip_acc_t;

  typedef struct packed {
    coord_t max_x;
    coord_t min_x;
    coord_t max_y;
    coord_t min_y;
    coord_t max_z;
    coord_t min_z;
  } box_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  coord_t              in_box_max_x = '0;
  coord_t              in_box_min_x = '0;
  coord_t              in_box_max_y = '0;
  coord_t              in_box_min_y = '0;
  coord_t              in_box_max_z = '0;
  coord_t              in_box_min_z = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic                out_visible;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Model of the programmed matrix, column-major, identity after reset.
  coord_t      view_mat [NUM_ENTRIES] = '{ONE, 0, 0, 0, 0, ONE, 0, 0,
                                          0, 0, ONE, 0, 0, 0, 0, ONE};
  box_t        pending_boxes [$];
  logic        visibility_due [$];
  box_t        box_on_bus;
  int unsigned in_gap       = 0;
  int unsigned out_stall    = 0;
  int unsigned boxes_sent   = 0;
  int unsigned results_seen = 0;
  bit          in_burst     = 1'b0;
  bit          out_burst    = 1'b0;
  int unsigned errors       = 0;
  int unsigned cycles       = 0;

  aabb_frustum_corner_test_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_box_max_x (in_box_max_x),
    .in_box_min_x (in_box_min_x),
    .in_box_max_y (in_box_max_y),
    .in_box_min_y (in_box_min_y),
    .in_box_max_z (in_box_max_z),
    .in_box_min_z (in_box_min_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_visible  (out_visible),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact clip-space test of all eight corners against the current matrix.
  function automatic logic box_in_view(box_t b);
    coord_t    xs [2];
    coord_t    ys [2];
    coord_t    zs [2];
    clip_acc_t acc [NUM_ROWS];
    logic      hit;
    logic      corner_ok;
    int        c;
    int        r;
    xs[0] = b.max_x;
    xs[1] = b.min_x;
    ys[0] = b.max_y;
    ys[1] = b.min_y;
    zs[0] = b.max_z;
    zs[1] = b.min_z;
    hit = 1'b0;
    for (c = 0; c < NUM_CORNERS; c++) begin
      for (r = 0; r < NUM_ROWS; r++) begin
        acc[r] = clip_acc_t'(view_mat[r])     * clip_acc_t'(xs[c % 2])
               + clip_acc_t'(view_mat[r + 4]) * clip_acc_t'(ys[(c / 2) % 2])
               + clip_acc_t'(view_mat[r + 8]) * clip_acc_t'(zs[c / 4])
               + (clip_acc_t'(view_mat[r + 12]) <<< W_SHIFT);
      end
      corner_ok = 1'b1;
      for (r = 0; r < W_ROW; r++) begin
        if (acc[r] < -acc[W_ROW] || acc[r] > acc[W_ROW]) corner_ok = 1'b0;
      end
      if (corner_ok) hit = 1'b1;
    end
    return hit;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic coord_t rand_span(int unsigned lim);
    return coord_t'($urandom_range(0, 2 * lim)) - coord_t'(lim);
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return CMAX;
      1: return CMIN;
      2: return 0;
      3: return ONE;
      4: return -ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic box_t rand_box();
    box_t        b;
    coord_t      lo [3];
    coord_t      hi [3];
    coord_t      ctr;
    coord_t      half;
    coord_t      tmp;
    int unsigned kind;
    int          a;
    kind = $urandom_range(0, 99);
    for (a = 0; a < 3; a++) begin
      ctr   = rand_span(4 * ONE);
      half  = $urandom_range(0, 2 * ONE);
      lo[a] = ctr - half;
      hi[a] = ctr + half;
      if (kind >= 85 && kind < 93 && $urandom_range(0, 1)) begin
        tmp   = lo[a];
        lo[a] = hi[a];
        hi[a] = tmp;
      end
    end
    b = '{max_x: hi[0], min_x: lo[0], max_y: hi[1], min_y: lo[1],
          max_z: hi[2], min_z: lo[2]};
    if (kind >= 70 && kind < 85) begin
      b = '{max_x: $urandom, min_x: $urandom, max_y: $urandom, min_y: $urandom,
            max_z: $urandom, min_z: $urandom};
    end else if (kind >= 93) begin
      b = '{max_x: pick_extreme(), min_x: pick_extreme(), max_y: pick_extreme(),
            min_y: pick_extreme(), max_z: pick_extreme(), min_z: pick_extreme()};
    end
    return b;
  endfunction

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) visibility_due.push_back(box_in_view(box_on_bus));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap   = in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_boxes.size() > 0) begin
          box_on_bus = pending_boxes.pop_front();
          in_box_max_x <= box_on_bus.max_x;
          in_box_min_x <= box_on_bus.min_x;
          in_box_max_y <= box_on_bus.max_y;
          in_box_min_y <= box_on_bus.min_y;
          in_box_max_z <= box_on_bus.max_z;
          in_box_min_z <= box_on_bus.min_z;
          in_valid     <= 1'b1;
          boxes_sent = boxes_sent + 1;
          if (boxes_sent % 50 == 0) in_burst = ($urandom_range(0, 3) == 0);
          in_gap = pick_gap(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (visibility_due.size() == 0) begin
          $display("%0t: unexpected transaction, visible %0b", $time, out_visible);
          errors = errors + 1;
        end else if (visibility_due[0] !== out_visible) begin
          $display("%0t: visible mismatch, expected %0b, actual %0b",
                   $time, visibility_due[0], out_visible);
          errors = errors + 1;
          void'(visibility_due.pop_front());
        end else begin
          void'(visibility_due.pop_front());
        end
        results_seen = results_seen + 1;
        if (results_seen % 50 == 0) out_burst = ($urandom_range(0, 3) == 0);
        out_stall = pick_gap(out_burst);
      end
      if (out_stall > 0) begin
        out_stall = out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d transactions still expected", $time, visibility_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_pair(input int k, input pair_t value);
    logic [ADDR_W-1:0] addr;
    addr = ADDR_W'(k * PAIR_STRIDE);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    view_mat[2 * k]     = value[31:0];
    view_mat[2 * k + 1] = value[63:32];
  endtask

  task automatic load_matrix(input coord_t m [NUM_ENTRIES]);
    int k;
    for (k = 0; k < NUM_PAIRS; k++) write_pair(k, {m[2 * k + 1], m[2 * k]});
  endtask

  task automatic push_box(input coord_t mx, input coord_t nx, input coord_t my,
                          input coord_t ny, input coord_t mz, input coord_t nz);
    pending_boxes.push_back('{max_x: mx, min_x: nx, max_y: my, min_y: ny,
                              max_z: mz, min_z: nz});
  endtask

  task automatic push_random(input int n);
    int i;
    for (i = 0; i < n; i++) pending_boxes.push_back(rand_box());
  endtask

  // Block idle: nothing queued, on the bus or in flight.
  task automatic settle();
    while (pending_boxes.size() != 0 || in_valid || visibility_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic void set_identity(ref coord_t m [NUM_ENTRIES]);
    int i;
    for (i = 0; i < NUM_ENTRIES; i++) m[i] = (i % 5 == 0) ? ONE : 0;
  endfunction

  initial begin
    coord_t m [NUM_ENTRIES];
    int     i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // identity after reset: boundaries, spanning box, swapped min/max
    push_box(0, 0, 0, 0, 0, 0);
    push_box(ONE, -ONE, ONE, -ONE, ONE, -ONE);
    push_box(2 * ONE, ONE + 1, ONE, -ONE, ONE, -ONE);
    push_box(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
    push_box(-ONE, ONE, -ONE, ONE, -ONE, ONE);
    push_box(-3 * ONE, 3 * ONE, -3 * ONE, 3 * ONE, -3 * ONE, 3 * ONE);
    push_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    push_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    push_box(5 * ONE, ONE / 2, 5 * ONE, ONE / 2, 5 * ONE, ONE / 2);
    push_box(-ONE - 1, -ONE - 1, -ONE - 1, -ONE - 1, -ONE - 1, -ONE - 1);
    push_box(ONE, ONE, -ONE, -ONE, ONE, -ONE);
    push_random(RAND_BOXES);
    settle();

    // perspective-like: w = -z
    for (i = 0; i < NUM_ENTRIES; i++) m[i] = 0;
    m[0]  = ONE;
    m[5]  = ONE;
    m[10] = -ONE;
    m[11] = -ONE;
    m[14] = -ONE / 4;
    load_matrix(m);
    push_random(RAND_BOXES);
    settle();

    // small random entries, w kept mostly positive
    for (i = 0; i < NUM_ENTRIES; i++) m[i] = rand_span(ONE);
    m[3]  = rand_span(ONE / 8);
    m[7]  = rand_span(ONE / 8);
    m[11] = rand_span(ONE / 8);
    m[15] = $urandom_range(ONE / 2, 4 * ONE);
    load_matrix(m);
    push_random(RAND_BOXES);
    settle();

    // full-range entries
    for (i = 0; i < NUM_ENTRIES; i++) m[i] = $urandom;
    load_matrix(m);
    push_random(RAND_BOXES);
    settle();

    // extreme entries
    for (i = 0; i < NUM_ENTRIES; i++) m[i] = (i % 3 == 0) ? CMIN : CMAX;
    load_matrix(m);
    push_box(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
    push_random(RAND_BOXES);
    settle();

    // zero w: only the exact origin is inside
    set_identity(m);
    m[15] = 0;
    load_matrix(m);
    push_box(0, 0, 0, 0, 0, 0);
    push_box(1, 1, 0, 0, 0, 0);
    push_box(0, 0, 0, 0, 1, -1);
    push_random(RAND_BOXES);
    settle();

    // negative w: nothing can be inside
    set_identity(m);
    m[15] = -ONE;
    load_matrix(m);
    push_box(0, 0, 0, 0, 0, 0);
    push_random(RAND_BOXES);
    settle();

    // identity with a shift along x, written explicitly
    set_identity(m);
    m[12] = ONE / 2;
    load_matrix(m);
    push_box(ONE / 2, ONE / 2, 0, 0, 0, 0);
    push_box(-3 * ONE / 2, -3 * ONE / 2, 0, 0, 0, 0);
    push_random(RAND_BOXES);
    settle();

    if (errors == 0 && visibility_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
